// ===== src/cpp_pkg.sv =====
// shared types and constants for the closest point pair finder
// no dependencies; imported by every module of the block but cpp_ram
`default_nettype none

package cpp_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 8;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int SQR_BITS   = 2 * COORD_BITS;
   localparam int SQ_BITS    = SQR_BITS + 1;
   localparam int FRAC_BITS  = 8;
   localparam int FIX_BITS   = 17;
   localparam int ROOT_STEPS = FIX_BITS;
   localparam int RAD_BITS   = 2 * ROOT_STEPS;
   localparam int REM_BITS   = FIX_BITS + 3;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic                  last_point;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] first_x;
      logic [COORD_BITS-1:0] first_y;
      logic [COORD_BITS-1:0] second_x;
      logic [COORD_BITS-1:0] second_y;
      logic [IDX_BITS-1:0]   first_index;
      logic [IDX_BITS-1:0]   second_index;
      logic [SQ_BITS-1:0]    squared_distance;
      logic [FIX_BITS-1:0]   distance_fixed;
      logic                  found;
      logic                  overflow;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/cpp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module cpp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/cpp_sqdist.sv =====
// squared distance unit: one shared squarer used for dx then dy
// depends on cpp_pkg
`default_nettype none

module cpp_sqdist (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire cpp_pkg::point_type pa,
   input  wire cpp_pkg::point_type pb,
   output logic                   done,
   output logic [cpp_pkg::SQ_BITS-1:0] sq
);
   import cpp_pkg::*;

   typedef enum logic [1:0] {
      SD_IDLE,
      SD_SQ_X,
      SD_SQ_Y
   } sd_state_type;

   sd_state_type          state_ff, state_in;
   logic [COORD_BITS-1:0] dx_ff, dx_in;
   logic [COORD_BITS-1:0] dy_ff, dy_in;
   logic [SQ_BITS-1:0]    acc_ff, acc_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS-1:0] sq_op;
   logic [SQR_BITS-1:0]   prod;

   // single multiplier, operand picked by state
   assign sq_op = (state_ff == SD_SQ_X) ? dx_ff : dy_ff;
   assign prod  = sq_op * sq_op;

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         SD_IDLE: begin
            if (start) begin
               dx_in    = (pa.x > pb.x) ? pa.x - pb.x : pb.x - pa.x;
               dy_in    = (pa.y > pb.y) ? pa.y - pb.y : pb.y - pa.y;
               state_in = SD_SQ_X;
            end
         end
         SD_SQ_X: begin
            acc_in   = SQ_BITS'(prod);
            state_in = SD_SQ_Y;
         end
         SD_SQ_Y: begin
            acc_in   = acc_ff + SQ_BITS'(prod);
            done_in  = 1'b1;
            state_in = SD_IDLE;
         end
         default: state_in = SD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign sq   = acc_ff;

endmodule

`default_nettype wire

// ===== src/cpp_isqrt.sv =====
// bit-serial integer square root of value * 2^(2*FRAC_BITS), one root bit a cycle
// depends on cpp_pkg
`default_nettype none

module cpp_isqrt (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [cpp_pkg::SQ_BITS-1:0] value,
   output logic                         done,
   output logic [cpp_pkg::FIX_BITS-1:0] root
);
   import cpp_pkg::*;

   typedef enum logic [0:0] {
      RT_IDLE,
      RT_RUN
   } rt_state_type;

   localparam int STEP_BITS = $clog2(ROOT_STEPS);

   rt_state_type         state_ff, state_in;
   logic [RAD_BITS-1:0]  rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [FIX_BITS-1:0]  root_ff, root_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 done_ff, done_in;
   logic [REM_BITS-1:0]  rem_shift;
   logic [REM_BITS-1:0]  trial;

   // bring down the next two radicand bits and try a one in the root
   assign rem_shift = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial     = REM_BITS'({root_ff, 2'b01});

   always_comb begin
      state_in = state_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         RT_IDLE: begin
            if (start) begin
               rad_in   = RAD_BITS'({value, {(2 * FRAC_BITS){1'b0}}});
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = RT_RUN;
            end
         end
         RT_RUN: begin
            rad_in = {rad_ff[RAD_BITS-3:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[FIX_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[FIX_BITS-2:0], 1'b0};
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(ROOT_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = RT_IDLE;
            end
         end
         default: state_in = RT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ===== src/closest_point_pair_finder.sv =====
// closest pair of 2-d points by exhaustive pair search, with point store,
// shared squared-distance unit and serial square root; depends on cpp_pkg,
// cpp_ram, cpp_sqdist and cpp_isqrt
//
//   channel   dir   beat                               handshake
//   req_      in    one point, last_point ends a set   req_valid / req_ready
//   rsp_      out   closest pair of the set            rsp_valid / rsp_ready
//
// req_ready is high only while loading points; a beat needs req_valid as well
// after the last point the search reads each row in S_ROW and S_ROW_LATCH and
// runs each pair through S_DIST and S_WAIT, waiting on the shared squarer
// a root runs only if a pair was found; the result then enters the rsp register
// loading of the next set starts while a result still waits on rsp_ready
// reset clears the point count, drop flag and rsp_valid; no clearing pass
`default_nettype none

module closest_point_pair_finder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cpp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cpp_pkg::rsp_type      rsp_data
);
   import cpp_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_ROW,
      S_ROW_LATCH,
      S_DIST,
      S_WAIT,
      S_ROOT,
      S_ROOT_WAIT,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                dropped_ff, dropped_in;
   logic [IDX_BITS-1:0] i_ff, i_in;
   logic [IDX_BITS-1:0] j_ff, j_in;
   point_type           pi_ff, pi_in;
   point_type           pj_ff, pj_in;
   logic                have_ff, have_in;
   logic [SQ_BITS-1:0]  best_ff, best_in;
   logic [IDX_BITS-1:0] bi_ff, bi_in;
   logic [IDX_BITS-1:0] bj_ff, bj_in;
   point_type           bpi_ff, bpi_in;
   point_type           bpj_ff, bpj_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                req_beat;
   logic                wr_en;
   point_type           wr_point;
   logic [IDX_BITS-1:0] rd_addr;
   point_type           rd_point;
   logic [CNT_BITS-1:0] i_next;
   logic [CNT_BITS-1:0] j_next;
   logic                dist_start;
   logic                dist_done;
   logic [SQ_BITS-1:0]  dist_sq;
   logic                root_start;
   logic                root_done;
   logic [FIX_BITS-1:0] root_val;

   assign req_ready = (state_ff == S_LOAD);
   assign req_beat  = req_valid && req_ready;
   assign wr_en     = req_beat && (count_ff < CNT_BITS'(MAX_POINTS));
   assign wr_point  = '{x: req_data.point_x, y: req_data.point_y};
   assign i_next    = CNT_BITS'(i_ff) + CNT_BITS'(1);
   assign j_next    = CNT_BITS'(j_ff) + CNT_BITS'(1);

   cpp_ram #(
      .WIDTH($bits(point_type)),
      .DEPTH(MAX_POINTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[IDX_BITS-1:0]),
      .wr_data(wr_point),
      .rd_addr(rd_addr),
      .rd_data(rd_point)
   );

   cpp_sqdist u_sqdist (
      .clock(clock),
      .reset(reset),
      .start(dist_start),
      .pa   (pi_ff),
      .pb   (rd_point),
      .done (dist_done),
      .sq   (dist_sq)
   );

   cpp_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .start(root_start),
      .value(best_ff),
      .done (root_done),
      .root (root_val)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pi_in        = pi_ff;
      pj_in        = pj_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      bi_in        = bi_ff;
      bj_in        = bj_ff;
      bpi_in       = bpi_ff;
      bpj_in       = bpj_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = j_ff;
      dist_start   = 1'b0;
      root_start   = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_beat) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_point) begin
                  i_in     = '0;
                  have_in  = 1'b0;
                  state_in = S_ROW;
               end
            end
         end
         S_ROW: begin
            if (i_next < count_ff) begin
               rd_addr  = i_ff;
               j_in     = i_next[IDX_BITS-1:0];
               state_in = S_ROW_LATCH;
            end else begin
               state_in = S_ROOT;
            end
         end
         S_ROW_LATCH: begin
            pi_in    = rd_point;
            rd_addr  = j_ff;
            state_in = S_DIST;
         end
         S_DIST: begin
            pj_in      = rd_point;
            dist_start = 1'b1;
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            if (dist_done) begin
               // coincident points are skipped, ties keep the earlier pair
               if (dist_sq != '0 && (!have_ff || dist_sq < best_ff)) begin
                  have_in = 1'b1;
                  best_in = dist_sq;
                  bi_in   = i_ff;
                  bj_in   = j_ff;
                  bpi_in  = pi_ff;
                  bpj_in  = pj_ff;
               end
               if (j_next < count_ff) begin
                  j_in     = j_next[IDX_BITS-1:0];
                  rd_addr  = j_next[IDX_BITS-1:0];
                  state_in = S_DIST;
               end else begin
                  i_in     = i_next[IDX_BITS-1:0];
                  state_in = S_ROW;
               end
            end
         end
         S_ROOT: begin
            if (have_ff) begin
               root_start = 1'b1;
               state_in   = S_ROOT_WAIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_ROOT_WAIT: begin
            if (root_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in                   = '0;
               rsp_data_in.overflow          = dropped_ff;
               if (have_ff) begin
                  rsp_data_in.first_x          = bpi_ff.x;
                  rsp_data_in.first_y          = bpi_ff.y;
                  rsp_data_in.second_x         = bpj_ff.x;
                  rsp_data_in.second_y         = bpj_ff.y;
                  rsp_data_in.first_index      = bi_ff;
                  rsp_data_in.second_index     = bj_ff;
                  rsp_data_in.squared_distance = best_ff;
                  rsp_data_in.distance_fixed   = root_val;
                  rsp_data_in.found            = 1'b1;
               end
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      pi_ff       <= pi_in;
      pj_ff       <= pj_in;
      best_ff     <= best_in;
      bi_ff       <= bi_in;
      bj_ff       <= bj_in;
      bpi_ff      <= bpi_in;
      bpj_ff      <= bpj_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside finish");

   a_found_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.found |->
         rsp_data_ff.first_index < rsp_data_ff.second_index &&
         rsp_data_ff.squared_distance != '0)
      else $error("found pair has bad order or zero distance");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |->
         rsp_data_ff.squared_distance == '0 && rsp_data_ff.distance_fixed == '0)
      else $error("empty result carries a distance");

   a_dist_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      dist_done |-> state_ff == S_WAIT)
      else $error("distance result arrived outside wait");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking bench for closest_point_pair_finder: loads point sets, predicts the
// closest pair of each set and checks every response beat; depends on cpp_pkg and the rtl
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cpp_pkg::*;

   localparam int TOTAL_POINTS = 1100;
   localparam int MAX_GAP      = 12;
   localparam int MAX_STALL    = 64;
   localparam int SETTLE       = 2 * MAX_POINTS * MAX_POINTS + 64;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_COIN, READY_EVERY_NINTH, READY_SPARSE
   } ready_mode_type;

   typedef enum logic [1:0] {
      SHAPE_SPREAD, SHAPE_CLUSTER, SHAPE_STACKED
   } shape_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // point beats waiting to go out, with a flag to hold off until all sets are answered
   req_type pending_points[$];
   bit      pending_hold[$];

   // predictor state and expected closest pairs
   point_type   held_points[MAX_POINTS];
   int unsigned held_count;
   bit          held_dropped;
   rsp_type     expected_pairs[$];

   int unsigned    queued_points, queued_sets, open_set_size;
   int unsigned    sets_closed, results_seen;
   int unsigned    results_checked, empty_results, dropped_sets, mismatch_count;
   int unsigned    burst_left, gap_left, mode_left, stall_tick;
   ready_mode_type ready_mode;
   longint unsigned cycle_count = 0;
   longint unsigned cycle_limit = 64'd4_000_000;
   longint unsigned cycle_budget;

   closest_point_pair_finder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // floor(sqrt(sq) * 2^FRAC_BITS), one result bit per trial
   function automatic logic [FIX_BITS-1:0] fixed_root(int unsigned sq);
      longint unsigned radicand, trial;
      logic [FIX_BITS-1:0] root;
      radicand = 64'(sq) << (2 * FRAC_BITS);
      root = '0;
      for (int b = FIX_BITS - 1; b >= 0; b--) begin
         trial = 64'(root) | (64'd1 << b);
         if (trial * trial <= radicand) root[b] = 1'b1;
      end
      return root;
   endfunction

   function automatic rsp_type search_closest_pair();
      rsp_type     pair;
      int          dx, dy;
      int unsigned pair_sq, best;
      bit          have;
      pair = '0;
      have = 1'b0;
      best = 0;
      for (int i = 0; i < held_count; i++) begin
         for (int j = i + 1; j < held_count; j++) begin
            dx = int'(held_points[i].x) - int'(held_points[j].x);
            dy = int'(held_points[i].y) - int'(held_points[j].y);
            pair_sq = dx * dx + dy * dy;
            // coincident points never count; ties keep the earlier pair
            if (pair_sq != 0 && (!have || pair_sq < best)) begin
               have = 1'b1;
               best = pair_sq;
               pair.first_x      = held_points[i].x;
               pair.first_y      = held_points[i].y;
               pair.second_x     = held_points[j].x;
               pair.second_y     = held_points[j].y;
               pair.first_index  = i[IDX_BITS-1:0];
               pair.second_index = j[IDX_BITS-1:0];
            end
         end
      end
      if (have) begin
         pair.squared_distance = best[SQ_BITS-1:0];
         pair.distance_fixed   = fixed_root(best);
         pair.found            = 1'b1;
      end
      pair.overflow = held_dropped;
      return pair;
   endfunction

   function automatic void load_point(req_type beat);
      if (held_count < MAX_POINTS) begin
         held_points[held_count] = '{x: beat.point_x, y: beat.point_y};
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (beat.last_point) begin
         expected_pairs.push_back(search_closest_pair());
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s of result %0d: expected %0d, got %0d",
                     name, results_checked, want, got);
      end
   endfunction

   function automatic void check_pair(rsp_type got);
      rsp_type want;
      if (expected_pairs.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("response beat with no set pending: %p", got);
         return;
      end
      want = expected_pairs.pop_front();
      check_field("first_x",          want.first_x,          got.first_x);
      check_field("first_y",          want.first_y,          got.first_y);
      check_field("second_x",         want.second_x,         got.second_x);
      check_field("second_y",         want.second_y,         got.second_y);
      check_field("first_index",      want.first_index,      got.first_index);
      check_field("second_index",     want.second_index,     got.second_index);
      check_field("squared_distance", want.squared_distance, got.squared_distance);
      check_field("distance_fixed",   want.distance_fixed,   got.distance_fixed);
      check_field("found",            want.found,            got.found);
      check_field("overflow",         want.overflow,         got.overflow);
      results_checked++;
      if (!want.found) empty_results++;
      if (want.overflow) dropped_sets++;
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic add_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                            bit last, bit hold);
      int unsigned stored;
      pending_points.push_back('{point_x: x, point_y: y, last_point: last});
      pending_hold.push_back(hold);
      queued_points++;
      open_set_size++;
      cycle_budget += MAX_GAP + 1;
      if (last) begin
         stored = (open_set_size > MAX_POINTS) ? MAX_POINTS : open_set_size;
         cycle_budget += 2 * stored * stored + 2 * stored + 80 + MAX_STALL;
         open_set_size = 0;
         queued_sets++;
      end
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   task automatic add_random_set(int unsigned size, bit hold);
      shape_type              shape;
      logic [COORD_BITS-1:0]  base_x, base_y, x, y;
      shape = shape_type'($urandom_range(0, 9) < 5 ? SHAPE_SPREAD :
                          $urandom_range(0, 7) < 7 ? SHAPE_CLUSTER : SHAPE_STACKED);
      base_x = pick_coord();
      base_y = pick_coord();
      if (base_x > 252) base_x = 252;
      if (base_y > 252) base_y = 252;
      for (int unsigned k = 0; k < size; k++) begin
         case (shape)
            SHAPE_SPREAD: begin
               x = pick_coord();
               y = pick_coord();
            end
            SHAPE_CLUSTER: begin
               // tight window: many ties and coincident points
               x = base_x + COORD_BITS'($urandom_range(0, 3));
               y = base_y + COORD_BITS'($urandom_range(0, 3));
            end
            default: begin
               x = base_x;
               y = base_y;
               if ($urandom_range(0, 15) == 0) x = base_x + COORD_BITS'(1);
            end
         endcase
         add_point(x, y, k == size - 1, hold && k == 0);
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready && req_data.last_point) sets_closed++;
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_points.size() > 0 &&
                         !(pending_hold[0] && sets_closed != results_seen)) begin
               req_valid <= 1'b1;
               req_data  <= pending_points.pop_front();
               void'(pending_hold.pop_front());
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         held_count   = 0;
         held_dropped = 1'b0;
         mode_left    = 0;
         stall_tick   = 0;
      end else begin
         if (req_valid && req_ready) load_point(req_data);
         if (rsp_valid && rsp_ready) begin
            check_pair(rsp_data);
            results_seen <= results_seen + 1;
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         stall_tick++;
         case (ready_mode)
            READY_ALWAYS:      rsp_ready <= 1'b1;
            READY_COIN:        rsp_ready <= 1'($urandom_range(0, 1));
            READY_EVERY_NINTH: rsp_ready <= (stall_tick % 9 == 0);
            default:           rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("timeout after %0d cycles, %0d of %0d sets answered",
                  cycle_count, results_seen, queued_sets);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int unsigned pick, size;

      // lone point, then a coincident pair: no pair at nonzero distance
      add_point(8'd0, 8'd0, 1'b1, 1'b0);
      add_point(8'd255, 8'd255, 1'b0, 1'b0);
      add_point(8'd255, 8'd255, 1'b1, 1'b0);
      // opposite corners, largest distance
      add_point(8'd0, 8'd0, 1'b0, 1'b0);
      add_point(8'd255, 8'd255, 1'b1, 1'b0);
      // two equal distances, the earlier pair wins
      add_point(8'd255, 8'd0, 1'b0, 1'b0);
      add_point(8'd0, 8'd255, 1'b0, 1'b0);
      add_point(8'd0, 8'd0, 1'b1, 1'b0);
      add_point(8'd10, 8'd10, 1'b0, 1'b0);
      add_point(8'd11, 8'd10, 1'b0, 1'b0);
      add_point(8'd12, 8'd10, 1'b1, 1'b0);
      // coincident pair skipped in favor of a farther one
      add_point(8'd5, 8'd5, 1'b0, 1'b0);
      add_point(8'd5, 8'd5, 1'b0, 1'b0);
      add_point(8'd6, 8'd5, 1'b1, 1'b0);
      add_point(8'hAA, 8'h55, 1'b0, 1'b0);
      add_point(8'h55, 8'hAA, 1'b1, 1'b0);

      // exactly full store, then one more point so the closing point is dropped
      add_random_set(MAX_POINTS, 1'b1);
      add_random_set(MAX_POINTS + 1, 1'b0);
      add_random_set(MAX_POINTS + 6, 1'b1);
      while (queued_points < TOTAL_POINTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)       size = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 8);
         else if (pick < 8)  size = $urandom_range(13, 40);
         else if (pick < 12) size = 1;
         else                size = $urandom_range(2, 12);
         add_random_set(size, $urandom_range(0, 9) == 0);
      end
      cycle_limit = 4 * cycle_budget + 4 * SETTLE + 20000;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_points.size() != 0 || req_valid) @(negedge clock);
      while (expected_pairs.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("%0d points in %0d sets loaded; %0d closest pairs checked,",
               queued_points, queued_sets, results_checked);
      $display("%0d with no pair at nonzero distance, %0d with dropped points",
               empty_results, dropped_sets);
      if (mismatch_count == 0 && expected_pairs.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d sets unanswered", mismatch_count,
                  expected_pairs.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
src/cpp_pkg.sv
src/cpp_ram.sv
src/cpp_sqdist.sv
src/cpp_isqrt.sv
src/closest_point_pair_finder.sv
tb/tb_top.sv
